### sv/utf8_to_cp437_converter_assert.svh
// assertion macros shared by the converter checks
`ifndef UTF8_TO_CP437_CONVERTER_ASSERT_SVH
`define UTF8_TO_CP437_CONVERTER_ASSERT_SVH
// same-cycle implication
`define UTC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define UTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

### sv/utc_pkg.sv
// types, codes and glyph table for the utf-8 to cp437 converter
`default_nettype none
package utc_pkg;
   localparam int MaxResults = 4;
   localparam int ContDepth = 3;

   typedef enum logic [1:0] {
      KIND_PASS     = 2'd0,
      KIND_CONV     = 2'd1,
      KIND_BROKEN   = 2'd2,
      KIND_UNMAPPED = 2'd3
   } kind_type;

   typedef struct packed {
      logic [MaxResults-1:0][7:0] data;
      kind_type [MaxResults-1:0]   kind;
      logic [2:0]                  count;
   } result_set_type;

   // returns {hit, glyph}
   function automatic logic [8:0] glyph_lookup(input logic [20:0] cp);
      logic [8:0] r;
      r = 9'h000;
      case (cp)
         21'h00A0: r = {1'b1, 8'hFF}; 21'h00A1: r = {1'b1, 8'hAD}; 21'h00A2: r = {1'b1, 8'h9B};
         21'h00A3: r = {1'b1, 8'h9C}; 21'h00A5: r = {1'b1, 8'h9D}; 21'h00A7: r = {1'b1, 8'h15};
         21'h00AA: r = {1'b1, 8'hA6}; 21'h00AB: r = {1'b1, 8'hAE}; 21'h00AC: r = {1'b1, 8'hAA};
         21'h00B0: r = {1'b1, 8'hF8}; 21'h00B1: r = {1'b1, 8'hF1}; 21'h00B2: r = {1'b1, 8'hFD};
         21'h00B5: r = {1'b1, 8'hE6}; 21'h00B6: r = {1'b1, 8'h14}; 21'h00B7: r = {1'b1, 8'hFA};
         21'h00BA: r = {1'b1, 8'hA7}; 21'h00BB: r = {1'b1, 8'hAF}; 21'h00BC: r = {1'b1, 8'hAC};
         21'h00BD: r = {1'b1, 8'hAB}; 21'h00BF: r = {1'b1, 8'hA8}; 21'h00C4: r = {1'b1, 8'h8E};
         21'h00C5: r = {1'b1, 8'h8F}; 21'h00C6: r = {1'b1, 8'h92}; 21'h00C7: r = {1'b1, 8'h80};
         21'h00C9: r = {1'b1, 8'h90}; 21'h00D1: r = {1'b1, 8'hA5}; 21'h00D6: r = {1'b1, 8'h99};
         21'h00DC: r = {1'b1, 8'h9A}; 21'h00DF: r = {1'b1, 8'hE1}; 21'h00E0: r = {1'b1, 8'h85};
         21'h00E1: r = {1'b1, 8'hA0}; 21'h00E2: r = {1'b1, 8'h83}; 21'h00E4: r = {1'b1, 8'h84};
         21'h00E5: r = {1'b1, 8'h86}; 21'h00E6: r = {1'b1, 8'h91}; 21'h00E7: r = {1'b1, 8'h87};
         21'h00E8: r = {1'b1, 8'h8A}; 21'h00E9: r = {1'b1, 8'h82}; 21'h00EA: r = {1'b1, 8'h88};
         21'h00EB: r = {1'b1, 8'h89}; 21'h00EC: r = {1'b1, 8'h8D}; 21'h00ED: r = {1'b1, 8'hA1};
         21'h00EE: r = {1'b1, 8'h8C}; 21'h00EF: r = {1'b1, 8'h8B}; 21'h00F1: r = {1'b1, 8'hA4};
         21'h00F2: r = {1'b1, 8'h95}; 21'h00F3: r = {1'b1, 8'hA2}; 21'h00F4: r = {1'b1, 8'h93};
         21'h00F6: r = {1'b1, 8'h94}; 21'h00F7: r = {1'b1, 8'hF6}; 21'h00F9: r = {1'b1, 8'h97};
         21'h00FA: r = {1'b1, 8'hA3}; 21'h00FB: r = {1'b1, 8'h96}; 21'h00FC: r = {1'b1, 8'h81};
         21'h00FF: r = {1'b1, 8'h98}; 21'h0192: r = {1'b1, 8'h9F};
         21'h0393: r = {1'b1, 8'hE2}; 21'h0398: r = {1'b1, 8'hE9}; 21'h03A3: r = {1'b1, 8'hE4};
         21'h03A6: r = {1'b1, 8'hE8}; 21'h03A9: r = {1'b1, 8'hEA}; 21'h03B1: r = {1'b1, 8'hE0};
         21'h03B4: r = {1'b1, 8'hEB}; 21'h03B5: r = {1'b1, 8'hEE}; 21'h03C0: r = {1'b1, 8'hE3};
         21'h03C3: r = {1'b1, 8'hE5}; 21'h03C4: r = {1'b1, 8'hE7}; 21'h03C6: r = {1'b1, 8'hED};
         21'h2022: r = {1'b1, 8'h07}; 21'h203C: r = {1'b1, 8'h13}; 21'h207F: r = {1'b1, 8'hFC};
         21'h20A7: r = {1'b1, 8'h9E};
         21'h2190: r = {1'b1, 8'h1B}; 21'h2191: r = {1'b1, 8'h18}; 21'h2192: r = {1'b1, 8'h1A};
         21'h2193: r = {1'b1, 8'h19}; 21'h2194: r = {1'b1, 8'h1D}; 21'h2195: r = {1'b1, 8'h12};
         21'h21A8: r = {1'b1, 8'h17};
         21'h2219: r = {1'b1, 8'hF9}; 21'h221A: r = {1'b1, 8'hFB}; 21'h221E: r = {1'b1, 8'hEC};
         21'h221F: r = {1'b1, 8'h1C}; 21'h2229: r = {1'b1, 8'hEF}; 21'h2248: r = {1'b1, 8'hF7};
         21'h2261: r = {1'b1, 8'hF0}; 21'h2264: r = {1'b1, 8'hF3}; 21'h2265: r = {1'b1, 8'hF2};
         21'h2302: r = {1'b1, 8'h7F}; 21'h2310: r = {1'b1, 8'hA9}; 21'h2320: r = {1'b1, 8'hF4};
         21'h2321: r = {1'b1, 8'hF5};
         21'h2500: r = {1'b1, 8'hC4}; 21'h2502: r = {1'b1, 8'hB3}; 21'h250C: r = {1'b1, 8'hDA};
         21'h2510: r = {1'b1, 8'hBF}; 21'h2514: r = {1'b1, 8'hC0}; 21'h2518: r = {1'b1, 8'hD9};
         21'h251C: r = {1'b1, 8'hC3}; 21'h2524: r = {1'b1, 8'hB4}; 21'h252C: r = {1'b1, 8'hC2};
         21'h2534: r = {1'b1, 8'hC1}; 21'h253C: r = {1'b1, 8'hC5}; 21'h2550: r = {1'b1, 8'hCD};
         21'h2551: r = {1'b1, 8'hBA}; 21'h2552: r = {1'b1, 8'hD5}; 21'h2553: r = {1'b1, 8'hD6};
         21'h2554: r = {1'b1, 8'hC9}; 21'h2555: r = {1'b1, 8'hB8}; 21'h2556: r = {1'b1, 8'hB7};
         21'h2557: r = {1'b1, 8'hBB}; 21'h2558: r = {1'b1, 8'hD4}; 21'h2559: r = {1'b1, 8'hD3};
         21'h255A: r = {1'b1, 8'hC8}; 21'h255B: r = {1'b1, 8'hBE}; 21'h255C: r = {1'b1, 8'hBD};
         21'h255D: r = {1'b1, 8'hBC}; 21'h255E: r = {1'b1, 8'hC6}; 21'h255F: r = {1'b1, 8'hC7};
         21'h2560: r = {1'b1, 8'hCC}; 21'h2561: r = {1'b1, 8'hB5}; 21'h2562: r = {1'b1, 8'hB6};
         21'h2563: r = {1'b1, 8'hB9}; 21'h2564: r = {1'b1, 8'hD1}; 21'h2565: r = {1'b1, 8'hD2};
         21'h2566: r = {1'b1, 8'hCB}; 21'h2567: r = {1'b1, 8'hCF}; 21'h2568: r = {1'b1, 8'hD0};
         21'h2569: r = {1'b1, 8'hCA}; 21'h256A: r = {1'b1, 8'hD8}; 21'h256B: r = {1'b1, 8'hD7};
         21'h256C: r = {1'b1, 8'hCE};
         21'h2580: r = {1'b1, 8'hDF}; 21'h2584: r = {1'b1, 8'hDC}; 21'h2588: r = {1'b1, 8'hDB};
         21'h258C: r = {1'b1, 8'hDD}; 21'h2590: r = {1'b1, 8'hDE}; 21'h2591: r = {1'b1, 8'hB0};
         21'h2592: r = {1'b1, 8'hB1}; 21'h2593: r = {1'b1, 8'hB2};
         21'h25A0: r = {1'b1, 8'hFE}; 21'h25AC: r = {1'b1, 8'h16}; 21'h25B2: r = {1'b1, 8'h1E};
         21'h25BA: r = {1'b1, 8'h10}; 21'h25BC: r = {1'b1, 8'h1F}; 21'h25C4: r = {1'b1, 8'h11};
         21'h25CB: r = {1'b1, 8'h09}; 21'h25D8: r = {1'b1, 8'h08}; 21'h25D9: r = {1'b1, 8'h0A};
         21'h263A: r = {1'b1, 8'h01}; 21'h263B: r = {1'b1, 8'h02}; 21'h263C: r = {1'b1, 8'h0F};
         21'h2640: r = {1'b1, 8'h0C}; 21'h2642: r = {1'b1, 8'h0B}; 21'h2660: r = {1'b1, 8'h06};
         21'h2663: r = {1'b1, 8'h05}; 21'h2665: r = {1'b1, 8'h03}; 21'h2666: r = {1'b1, 8'h04};
         21'h266A: r = {1'b1, 8'h0D}; 21'h266B: r = {1'b1, 8'h0E};
         default: r = 9'h000;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

### sv/utf8_to_cp437_converter.sv
// utf-8 to cp437 converter: top level with register port
// Usage
//   req_* takes one text byte per request (tdata) or an end marker (tlast),
//   which flushes a half-received sequence. rsp_* gives result bytes
//   (tdata) with their kind in tuser; tlast marks the last result of a request.
//   A request yields zero to four results. Its results appear on rsp_* in the
//   cycle after acceptance; one-result requests stream at one per cycle while rsp_tready is high.
//   A request with several results occupies the output buffer until its last
//   result leaves, and the next request is taken in the cycle that result
//   leaves. The results pass through the four-entry output shift buffer.
//   A stalled rsp_tready holds the buffer, and req_tready stays low until the
//   last result of the held request leaves.
//   Reset empties the buffer, drops any partial sequence and turns conversion
//   on. csr register 0 (byte address 0), bit 0: convert enable.
`default_nettype none
module utf8_to_cp437_converter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // in_byte
   input  wire logic        req_tlast,   // end_of_stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // out_byte
   output logic [1:0]       rsp_tuser,   // kind
   output logic             rsp_tlast,   // last
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   logic enable_ff;
   logic accept;
   utc_pkg::result_set_type results;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {31'd0, enable_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         enable_ff <= csr_pwdata[0];
      end
   end

   assign accept = req_tvalid && req_tready;

   utc_decoder u_decoder (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .in_byte        (req_tdata),
      .end_of_stream  (req_tlast),
      .convert_enable (enable_ff),
      .results        (results)
   );

   utc_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .results   (results),
      .can_load  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_kind  (rsp_tuser),
      .out_last  (rsp_tlast)
   );
endmodule
`default_nettype wire

### sv/utc_decoder.sv
// sequence tracker: decodes one request into its set of result bytes
`default_nettype none
module utc_decoder (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire logic [7:0]              in_byte,
   input  wire logic                    end_of_stream,
   input  wire logic                    convert_enable,
   output utc_pkg::result_set_type      results
);
   logic        pending_ff, pending_in;
   logic [7:0]  lead_ff, lead_in;
   logic [utc_pkg::ContDepth-1:0][7:0] cont_ff, cont_in;
   logic [1:0]  needed_ff, needed_in;
   logic [1:0]  seen_ff, seen_in;
   logic [20:0] accum_ff, accum_in;

   logic [2:0]  seen1;
   logic [20:0] acc1;
   logic [20:0] least;
   logic [8:0]  hit;
   logic [2:0]  n;
   logic        fresh;
   logic        is_cont;

   always_comb begin
      pending_in = pending_ff;
      lead_in    = lead_ff;
      cont_in    = cont_ff;
      needed_in  = needed_ff;
      seen_in    = seen_ff;
      accum_in   = accum_ff;
      results    = '0;
      n          = 3'd0;
      fresh      = 1'b1;
      is_cont    = !end_of_stream && (in_byte[7:6] == 2'b10);
      seen1      = {1'b0, seen_ff} + 3'd1;
      acc1       = {accum_ff[14:0], in_byte[5:0]};
      case (needed_ff)
         2'd3:    least = 21'h10000;
         2'd2:    least = 21'h00800;
         default: least = 21'h00080;
      endcase
      hit = utc_pkg::glyph_lookup(acc1);

      if (pending_ff) begin
         if (is_cont) begin
            cont_in[seen_ff] = in_byte;
            seen_in  = seen1[1:0];
            accum_in = acc1;
            fresh    = 1'b0;
            if (seen1 >= {1'b0, needed_ff}) begin
               if (acc1 >= least && hit[8]) begin
                  results.data[0] = hit[7:0];
                  results.kind[0] = utc_pkg::KIND_CONV;
                  n = 3'd1;
               end else begin
                  results.data[0] = lead_ff;
                  results.kind[0] = (acc1 < least) ? utc_pkg::KIND_BROKEN
                                                   : utc_pkg::KIND_UNMAPPED;
                  n = 3'd1;
                  for (int k = 0; k < utc_pkg::ContDepth; k++) begin
                     if (k < int'(seen1)) begin
                        results.data[n] = cont_in[k];
                        results.kind[n] = results.kind[0];
                        n = n + 3'd1;
                     end
                  end
               end
               pending_in = 1'b0;
               seen_in    = 2'd0;
               needed_in  = 2'd0;
               accum_in   = '0;
            end
         end else begin
            // broken sequence: flush what was held, then take the byte afresh unless it is an end marker
            results.data[0] = lead_ff;
            results.kind[0] = utc_pkg::KIND_BROKEN;
            n = 3'd1;
            for (int k = 0; k < utc_pkg::ContDepth; k++) begin
               if (k < int'(seen_ff)) begin
                  results.data[n] = cont_ff[k];
                  results.kind[n] = utc_pkg::KIND_BROKEN;
                  n = n + 3'd1;
               end
            end
            pending_in = 1'b0;
            seen_in    = 2'd0;
            needed_in  = 2'd0;
            accum_in   = '0;
         end
      end

      if (fresh && !end_of_stream) begin
         if (convert_enable && in_byte >= 8'hC2) begin
            if (in_byte < 8'hE0) begin
               pending_in = 1'b1; needed_in = 2'd1; accum_in = {16'd0, in_byte[4:0]};
               lead_in = in_byte; seen_in = 2'd0;
            end else if (in_byte < 8'hF0) begin
               pending_in = 1'b1; needed_in = 2'd2; accum_in = {17'd0, in_byte[3:0]};
               lead_in = in_byte; seen_in = 2'd0;
            end else if (in_byte < 8'hF8) begin
               pending_in = 1'b1; needed_in = 2'd3; accum_in = {18'd0, in_byte[2:0]};
               lead_in = in_byte; seen_in = 2'd0;
            end else begin
               needed_in = 2'd0;
               results.data[n[1:0]] = in_byte;
               results.kind[n[1:0]] = utc_pkg::KIND_BROKEN;
               n = n + 3'd1;
            end
         end else begin
            results.data[n[1:0]] = in_byte;
            results.kind[n[1:0]] = utc_pkg::KIND_PASS;
            n = n + 3'd1;
         end
      end
      results.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         lead_ff    <= 8'd0;
         needed_ff  <= 2'd0;
         seen_ff    <= 2'd0;
         accum_ff   <= '0;
      end else if (accept) begin
         pending_ff <= pending_in;
         lead_ff    <= lead_in;
         needed_ff  <= needed_in;
         seen_ff    <= seen_in;
         accum_ff   <= accum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cont_ff <= cont_in;
      end
   end
endmodule
`default_nettype wire

### sv/utc_emitter.sv
// result buffer: holds one request's results and shifts them out
`default_nettype none
module utc_emitter (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  utc_pkg::result_set_type      results,
   output logic                         can_load,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output logic [7:0]                   out_byte,
   output logic [1:0]                   out_kind,
   output logic                         out_last
);
   logic [utc_pkg::MaxResults-1:0][7:0] data_ff, data_in;
   utc_pkg::kind_type [utc_pkg::MaxResults-1:0] kind_ff, kind_in;
   logic [2:0] count_ff, count_in;
   logic       take;

   assign out_valid = (count_ff != 3'd0);
   assign out_last  = (count_ff == 3'd1);
   assign out_byte  = data_ff[0];
   assign out_kind  = kind_ff[0];
   assign take      = out_valid && out_ready;
   assign can_load  = (count_ff == 3'd0) || (out_last && out_ready);

   always_comb begin
      data_in  = data_ff;
      kind_in  = kind_ff;
      count_in = count_ff;
      if (load) begin
         data_in  = results.data;
         kind_in  = results.kind;
         count_in = results.count;
      end else if (take) begin
         for (int k = 0; k < utc_pkg::MaxResults - 1; k++) begin
            data_in[k] = data_ff[k+1];
            kind_in[k] = kind_ff[k+1];
         end
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      kind_ff <= kind_in;
   end
endmodule
`default_nettype wire

### sv/utc_checker.sv
// port-level checks for the converter, bound to the top level
`default_nettype none
`include "utf8_to_cp437_converter_assert.svh"
module utc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);
   // a stalled result holds
   `UTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // no new request while more than one result is still queued
   `UTC_ASSERT_NOW(a_no_overlap, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready)
   // a converted glyph is always the only result of its request
   `UTC_ASSERT_NOW(a_conv_single, clock, reset, rsp_tvalid && rsp_tuser == utc_pkg::KIND_CONV, rsp_tlast)
   // nothing is left to send after reset
   `UTC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)
endmodule

bind utf8_to_cp437_converter utc_checker u_checker (.*);
`default_nettype wire
